/* hdl/swwb_pkg.sv */
package swwb_pkg;

   // Window and store geometry
   localparam int WINDOW_BYTES = 32;
   localparam int STORE_BYTES  = 65536;

   // Window entry address and byte count widths
   localparam int WIN_AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
   localparam int WIN_CW = $clog2(WINDOW_BYTES + 1);

   // Field widths
   localparam int OP_W   = 2;
   localparam int IDX_W  = 16;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 3;
   localparam int LEN_W  = 6;
   localparam int SIZE_W = 17;

   // Operation codes
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_READ_DATA  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OUT_RANGE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WRITEBACK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REFILL_REQ = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [IDX_W-1:0]  index;
      logic [BYTE_W-1:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] byte_out;
      logic [IDX_W-1:0]  address;
      logic [LEN_W-1:0]  length;
      logic              last;
   } rsp_type;

endpackage

/* hdl/single_window_writeback_buffer_unit.sv */
// One-window write-back byte cache in front of a backing store. A read or write
// that hits the window is accepted and its result strobes on rsp_valid in the
// next cycle, so hits stream at one transaction per clock. An index at or beyond
// the store size that misses the window answers out of range, also one per clock.
// A miss on a clean window issues a refill request in the cycle after acceptance;
// on a dirty window it first streams one writeback byte per cycle (as many bytes
// as the window holds, at most 32) and then the refill request, busy during that
// time. Fill bytes (operation 2) are taken one per cycle; after the final one
// the block is busy in its completion state to finish the pending read or write,
// whose result follows in the next cycle. The window memory has one read port,
// one write port and a registered read. Reads and writes arriving while a refill
// is outstanding, fill bytes with no refill outstanding, and operation 3 are
// taken and dropped without a result. Results cannot be stalled. store_size must
// only be written while the block is idle.
module single_window_writeback_buffer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  swwb_pkg::req_type  req_item,
   output logic               rsp_valid,
   output swwb_pkg::rsp_type  rsp_item,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);
   import swwb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITEBACK,
      ST_REFILL,
      ST_COMPLETE
   } state_type;

   state_type           state_ff;
   logic [15:0]         store_size_ff;
   logic [IDX_W-1:0]    window_start_ff;
   logic [SIZE_W-1:0]   window_stop_ff;
   logic [WIN_CW-1:0]   valid_count_ff;
   logic                dirty_ff;
   logic                awaiting_fill_ff;
   logic [WIN_CW-1:0]   fill_ptr_ff;
   logic [WIN_CW-1:0]   wb_cnt_ff;
   logic                pend_write_ff;
   logic [IDX_W-1:0]    pend_index_ff;
   logic [BYTE_W-1:0]   pend_byte_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic                byte_sel_ff;

   // Window memory
   logic [BYTE_W-1:0]   window_mem [WINDOW_BYTES];
   logic [BYTE_W-1:0]   mem_rd_ff;
   logic                mem_we;
   logic [WIN_AW-1:0]   mem_waddr;
   logic [BYTE_W-1:0]   mem_wdata;
   logic [WIN_AW-1:0]   mem_raddr;

   // Decode
   logic                accept;
   logic                is_rw;
   logic                is_fill;
   logic                hit;
   logic                out_range;
   logic [SIZE_W-1:0]   size;
   logic [IDX_W-1:0]    hit_diff;
   logic [WIN_AW-1:0]   hit_off;
   logic [IDX_W-1:0]    pend_diff;
   logic [WIN_AW-1:0]   pend_off;
   logic [WIN_CW-1:0]   fill_ptr_in;
   logic [WIN_CW-1:0]   wb_cnt_in;

   // Window placement for a miss
   logic [IDX_W-1:0]    miss_idx;
   logic [SIZE_W-1:0]   idx_plus_win;
   logic [SIZE_W-1:0]   new_start;
   logic [SIZE_W-1:0]   start_plus_win;
   logic [SIZE_W-1:0]   new_stop;
   logic [WIN_CW-1:0]   new_count;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign is_rw   = (req_item.operation == OP_READ) || (req_item.operation == OP_WRITE);
   assign is_fill = (req_item.operation == OP_FILL);

   assign size = (SIZE_W'(store_size_ff) < SIZE_W'(STORE_BYTES)) ?
                 SIZE_W'(store_size_ff) : SIZE_W'(STORE_BYTES);

   assign hit       = (req_item.index >= window_start_ff) &&
                      (SIZE_W'(req_item.index) < window_stop_ff);
   assign out_range = (SIZE_W'(req_item.index) >= size);

   assign hit_diff  = req_item.index - window_start_ff;
   assign hit_off   = (hit_diff >= IDX_W'(WINDOW_BYTES)) ? '0 : hit_diff[WIN_AW-1:0];
   assign pend_diff = pend_index_ff - window_start_ff;
   assign pend_off  = (pend_diff >= IDX_W'(WINDOW_BYTES)) ? '0 : pend_diff[WIN_AW-1:0];

   assign fill_ptr_in = fill_ptr_ff + WIN_CW'(1);
   assign wb_cnt_in   = wb_cnt_ff + WIN_CW'(1);

   // New window: at the index, else flush to the store end, else at zero
   assign miss_idx       = (state_ff == ST_IDLE) ? req_item.index : pend_index_ff;
   assign idx_plus_win   = SIZE_W'(miss_idx) + SIZE_W'(WINDOW_BYTES);
   always_comb begin
      if (idx_plus_win < size) begin
         new_start = SIZE_W'(miss_idx);
      end else if (size >= SIZE_W'(WINDOW_BYTES)) begin
         new_start = size - SIZE_W'(WINDOW_BYTES);
      end else begin
         new_start = '0;
      end
   end
   assign start_plus_win = new_start + SIZE_W'(WINDOW_BYTES);
   assign new_stop       = (start_plus_win > size) ? size : start_plus_win;
   assign new_count      = WIN_CW'(new_stop - new_start);

   // Memory port steering
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = fill_ptr_ff[WIN_AW-1:0];
      mem_wdata = req_item.byte_in;
      mem_raddr = hit_off;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_fill && awaiting_fill_ff &&
                fill_ptr_ff < WIN_CW'(WINDOW_BYTES)) begin
               mem_we = 1'b1;
            end else if (accept && is_rw && !awaiting_fill_ff) begin
               if (hit) begin
                  if (req_item.operation == OP_WRITE) begin
                     mem_we    = 1'b1;
                     mem_waddr = hit_off;
                  end
               end else begin
                  mem_raddr = '0;
               end
            end
         end
         ST_WRITEBACK: begin
            mem_raddr = wb_cnt_ff[WIN_AW-1:0];
         end
         ST_COMPLETE: begin
            mem_raddr = pend_off;
            if (pend_write_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_off;
               mem_wdata = pend_byte_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= window_mem[mem_raddr];
   end

   // Control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         store_size_ff    <= '0;
         window_start_ff  <= '0;
         window_stop_ff   <= '0;
         valid_count_ff   <= '0;
         dirty_ff         <= 1'b0;
         awaiting_fill_ff <= 1'b0;
         fill_ptr_ff      <= '0;
         wb_cnt_ff        <= '0;
         pend_write_ff    <= 1'b0;
         pend_index_ff    <= '0;
         pend_byte_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         byte_sel_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            store_size_ff <= csr_write_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && is_fill && awaiting_fill_ff) begin
                  fill_ptr_ff <= fill_ptr_in;
                  if (fill_ptr_in >= valid_count_ff) begin
                     awaiting_fill_ff <= 1'b0;
                     state_ff         <= ST_COMPLETE;
                  end
               end else if (accept && is_rw && !awaiting_fill_ff) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.byte_out  <= '0;
                  rsp_ff.length    <= '0;
                  if (hit) begin
                     rsp_ff.address <= req_item.index;
                     rsp_ff.last    <= 1'b1;
                     if (req_item.operation == OP_WRITE) begin
                        rsp_ff.kind <= KIND_WRITE_DONE;
                        byte_sel_ff <= 1'b0;
                        dirty_ff    <= 1'b1;
                     end else begin
                        rsp_ff.kind <= KIND_READ_DATA;
                        byte_sel_ff <= 1'b1;
                     end
                  end else if (out_range) begin
                     rsp_ff.kind    <= KIND_OUT_RANGE;
                     rsp_ff.address <= req_item.index;
                     rsp_ff.last    <= 1'b1;
                     byte_sel_ff    <= 1'b0;
                  end else begin
                     pend_write_ff <= (req_item.operation == OP_WRITE);
                     pend_index_ff <= req_item.index;
                     pend_byte_ff  <= req_item.byte_in;
                     if (dirty_ff) begin
                        // First writeback byte; entry zero is being read now
                        dirty_ff       <= 1'b0;
                        rsp_ff.kind    <= KIND_WRITEBACK;
                        rsp_ff.address <= window_start_ff;
                        rsp_ff.last    <= 1'b0;
                        byte_sel_ff    <= 1'b1;
                        wb_cnt_ff      <= WIN_CW'(1);
                        state_ff       <= (valid_count_ff > WIN_CW'(1)) ?
                                          ST_WRITEBACK : ST_REFILL;
                     end else begin
                        rsp_ff.kind      <= KIND_REFILL_REQ;
                        rsp_ff.address   <= new_start[IDX_W-1:0];
                        rsp_ff.length    <= LEN_W'(new_count);
                        rsp_ff.last      <= 1'b1;
                        byte_sel_ff      <= 1'b0;
                        window_start_ff  <= new_start[IDX_W-1:0];
                        window_stop_ff   <= new_stop;
                        valid_count_ff   <= new_count;
                        fill_ptr_ff      <= '0;
                        awaiting_fill_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_WRITEBACK: begin
               rsp_valid_ff    <= 1'b1;
               rsp_ff.kind     <= KIND_WRITEBACK;
               rsp_ff.byte_out <= '0;
               rsp_ff.address  <= window_start_ff + IDX_W'(wb_cnt_ff);
               rsp_ff.length   <= '0;
               rsp_ff.last     <= 1'b0;
               byte_sel_ff     <= 1'b1;
               wb_cnt_ff       <= wb_cnt_in;
               if (wb_cnt_in >= valid_count_ff) begin
                  state_ff <= ST_REFILL;
               end
            end
            ST_REFILL: begin
               rsp_valid_ff     <= 1'b1;
               rsp_ff.kind      <= KIND_REFILL_REQ;
               rsp_ff.byte_out  <= '0;
               rsp_ff.address   <= new_start[IDX_W-1:0];
               rsp_ff.length    <= LEN_W'(new_count);
               rsp_ff.last      <= 1'b1;
               byte_sel_ff      <= 1'b0;
               window_start_ff  <= new_start[IDX_W-1:0];
               window_stop_ff   <= new_stop;
               valid_count_ff   <= new_count;
               fill_ptr_ff      <= '0;
               awaiting_fill_ff <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            ST_COMPLETE: begin
               // Pending transaction finishes on the refilled window
               rsp_valid_ff    <= 1'b1;
               rsp_ff.byte_out <= '0;
               rsp_ff.address  <= pend_index_ff;
               rsp_ff.length   <= '0;
               rsp_ff.last     <= 1'b1;
               if (pend_write_ff) begin
                  rsp_ff.kind <= KIND_WRITE_DONE;
                  byte_sel_ff <= 1'b0;
                  dirty_ff    <= 1'b1;
               end else begin
                  rsp_ff.kind <= KIND_READ_DATA;
                  byte_sel_ff <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Result ports; read bytes come straight from the memory read register
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_item = rsp_ff;
      if (byte_sel_ff) begin
         rsp_item.byte_out = mem_rd_ff;
      end
   end

`ifndef SYNTHESIS
   // Writeback never runs while a refill is outstanding
   assert property (@(posedge clock) disable iff (reset)
      !(awaiting_fill_ff && (state_ff == ST_WRITEBACK)))
      else $error("writeback while refill outstanding");

   // Only writeback bytes are non-final results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last || (rsp_ff.kind == KIND_WRITEBACK)))
      else $error("non-final result of wrong kind");

   // A refill request always leaves the block waiting for fill bytes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind == KIND_REFILL_REQ)) |-> awaiting_fill_ff)
      else $error("refill request without fill wait");

   // Window byte count stays within the window
   assert property (@(posedge clock) disable iff (reset)
      valid_count_ff <= WIN_CW'(WINDOW_BYTES))
      else $error("window byte count overflow");

   // The pending transaction completes right after the final fill byte
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPLETE) |=> (rsp_valid_ff && rsp_ff.last &&
                                     (state_ff == ST_IDLE)))
      else $error("pending transaction not completed");
`endif

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swwb_pkg::*;

   // Operation code the block drops without a result
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   // Cycles allowed for dropped transactions still in flight before a register write
   localparam int SETTLE_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   single_window_writeback_buffer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Cache shadow state, reset values
   logic [BYTE_W-1:0] line_data [WINDOW_BYTES] = '{default: '0};
   int unsigned       line_start = 0;
   int unsigned       line_stop = 0;
   int unsigned       line_count = 0;
   int unsigned       fill_count = 0;
   bit                line_dirty = 1'b0;
   bit                refill_open = 1'b0;
   bit                held_write = 1'b0;
   logic [IDX_W-1:0]  held_index = '0;
   logic [BYTE_W-1:0] held_byte = '0;
   int unsigned       store_size = 0;

   rsp_type     results_due [$];
   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          burst_left = 0;
   bit          pacing_on = 1'b0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic void push_result(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] data,
                                       input logic [IDX_W-1:0] addr,
                                       input logic [LEN_W-1:0] len,
                                       input logic last);
      rsp_type r;
      r.kind     = kind;
      r.byte_out = data;
      r.address  = addr;
      r.length   = len;
      r.last     = last;
      results_due.push_back(r);
   endfunction

   // Cache behavior for one accepted transaction; queues the results it causes
   function automatic void predict_cache_step(input req_type r);
      int unsigned size, idx, offs, first, stop, i;
      size = (store_size < STORE_BYTES) ? store_size : STORE_BYTES;
      idx  = 32'(r.index);

      // fill byte: store it, complete the held access on the final one
      if (r.operation == OP_FILL) begin
         if (!refill_open) return;
         if (fill_count < WINDOW_BYTES) line_data[fill_count] = r.byte_in;
         fill_count++;
         if (fill_count < line_count) return;
         refill_open = 1'b0;
         offs = (held_index - line_start) & 32'hffff;
         if (offs >= WINDOW_BYTES) offs = 0;
         if (held_write) begin
            line_data[offs] = held_byte;
            line_dirty = 1'b1;
            push_result(KIND_WRITE_DONE, '0, held_index, '0, 1'b1);
         end else begin
            push_result(KIND_READ_DATA, line_data[offs], held_index, '0, 1'b1);
         end
         return;
      end
      if (r.operation == OP_UNUSED || refill_open) return;

      // window hit wins over the range check
      if (idx >= line_start && idx < line_stop) begin
         offs = idx - line_start;
         if (offs >= WINDOW_BYTES) offs = 0;
         if (r.operation == OP_WRITE) begin
            line_data[offs] = r.byte_in;
            line_dirty = 1'b1;
            push_result(KIND_WRITE_DONE, '0, r.index, '0, 1'b1);
         end else begin
            push_result(KIND_READ_DATA, line_data[offs], r.index, '0, 1'b1);
         end
         return;
      end
      if (idx >= size) begin
         push_result(KIND_OUT_RANGE, '0, r.index, '0, 1'b1);
         return;
      end

      // miss: write back a dirty window, then place the new one
      if (line_dirty) begin
         for (i = 0; i < line_count && i < WINDOW_BYTES; i++)
            push_result(KIND_WRITEBACK, line_data[i], IDX_W'(line_start + i), '0, 1'b0);
         line_dirty = 1'b0;
      end
      if (idx + WINDOW_BYTES < size) first = idx;
      else if (size >= WINDOW_BYTES) first = size - WINDOW_BYTES;
      else first = 0;
      stop = first + WINDOW_BYTES;
      if (stop > size) stop = size;
      line_start  = first;
      line_stop   = stop;
      line_count  = stop - first;
      fill_count  = 0;
      refill_open = 1'b1;
      held_write  = (r.operation == OP_WRITE);
      held_index  = r.index;
      held_byte   = r.byte_in;
      push_result(KIND_REFILL_REQ, '0, IDX_W'(first), LEN_W'(line_count), 1'b1);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d address %0h",
                     $time, rsp_item.kind, rsp_item.address);
            error_count++;
         end else begin
            want = results_due.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_item.kind));
            compare_field("byte_out", 32'(want.byte_out), 32'(rsp_item.byte_out));
            compare_field("address", 32'(want.address), 32'(rsp_item.address));
            compare_field("length", 32'(want.length), 32'(rsp_item.length));
            compare_field("last", 32'(want.last), 32'(rsp_item.last));
         end
      end
   end

   function automatic req_type make_req(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] data);
      req_type r;
      r.operation = op;
      r.index     = idx;
      r.byte_in   = data;
      return r;
   endfunction

   // Transaction the block drops in its current state
   function automatic req_type junk_item();
      logic [OP_W-1:0] op;
      if (refill_open) begin
         case ($urandom_range(0, 2))
            0:       op = OP_READ;
            1:       op = OP_WRITE;
            default: op = OP_UNUSED;
         endcase
      end else begin
         op = $urandom_range(0, 1) ? OP_FILL : OP_UNUSED;
      end
      return make_req(op, IDX_W'($urandom), BYTE_W'($urandom));
   endfunction

   // Index mix: window hits, window edges, store end, anywhere
   function automatic logic [IDX_W-1:0] pick_index();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40 && line_count != 0)
         return IDX_W'(line_start + $urandom_range(0, line_count - 1));
      if (sel < 55)
         return IDX_W'(line_start + $urandom_range(0, WINDOW_BYTES + 8) - 4);
      if (sel < 70)
         return IDX_W'(store_size - $urandom_range(0, WINDOW_BYTES + 8));
      if (sel < 90 && store_size != 0)
         return IDX_W'($urandom_range(0, store_size - 1));
      return IDX_W'($urandom);
   endfunction

   // One transaction; start stays high so the next can follow back to back
   task automatic send_item(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predict_cache_step(r);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender bursts with random gaps
   task automatic send_paced(input req_type r);
      if (pacing_on) begin
         if (burst_left == 0) begin
            hold_off($urandom_range(1, 7));
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      send_item(r);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only with the block idle
   task automatic set_store_size(input logic [15:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      store_size = 32'(value);
      csr_write_enable <= 1'b0;
   endtask

   // Feed the outstanding refill, with dropped transactions mixed in
   task automatic finish_refill(output int sent);
      sent = 0;
      while (refill_open) begin
         if ($urandom_range(0, 9) == 0) send_paced(junk_item());
         send_paced(make_req(OP_FILL, IDX_W'($urandom), BYTE_W'($urandom)));
         sent++;
      end
      if ($urandom_range(0, 19) == 0) send_paced(junk_item());
   endtask

   // Size 0: every miss answers out of range; unused op and stray fill are dropped
   task automatic test_empty_store();
      set_store_size(16'd0);
      send_item(make_req(OP_READ, 16'h0000, 8'h00));
      send_item(make_req(OP_WRITE, 16'hffff, 8'hff));
      send_item(make_req(OP_UNUSED, 16'hffff, 8'hff));
      send_item(make_req(OP_FILL, 16'h0000, 8'hab));
      drain_results();
   endtask

   // Small store: refill, accesses dropped while it is open, hits, range edge
   task automatic test_small_window_refill();
      int n;
      set_store_size(16'd8);
      send_item(make_req(OP_READ, 16'd6, 8'h00));
      send_item(make_req(OP_READ, 16'd3, 8'h00));
      for (n = 0; n < 3; n++)
         send_item(make_req(OP_FILL, 16'd0, BYTE_W'($urandom)));
      send_item(make_req(OP_WRITE, 16'd1, 8'h5a));
      while (refill_open)
         send_item(make_req(OP_FILL, 16'hffff, BYTE_W'($urandom)));
      send_item(make_req(OP_WRITE, 16'd7, 8'hff));
      send_item(make_req(OP_READ, 16'd7, 8'h00));
      send_item(make_req(OP_READ, 16'd8, 8'h00));
      send_item(make_req(OP_FILL, 16'd0, 8'h11));
      drain_results();
   endtask

   // Store shrunk below a filled window: hits are still served
   task automatic test_hit_after_shrink();
      set_store_size(16'd2);
      send_item(make_req(OP_READ, 16'd7, 8'h00));
      send_item(make_req(OP_WRITE, 16'd0, 8'h00));
      send_item(make_req(OP_READ, 16'd2, 8'h00));
      send_item(make_req(OP_READ, 16'd8, 8'h00));
      send_item(make_req(OP_READ, 16'd1, 8'h00));
      drain_results();
   endtask

   // Random reads and writes, each miss followed by its fill bytes
   task automatic test_random_traffic(input logic [15:0] size, input int item_goal,
                                      input bit idle);
      int items, sent;
      set_store_size(size);
      pacing_on  = idle;
      burst_left = 0;
      items      = 0;
      while (items < item_goal) begin
         if ($urandom_range(0, 9) == 0) begin
            send_paced(junk_item());
         end else begin
            send_paced(make_req($urandom_range(0, 1) ? OP_WRITE : OP_READ, pick_index(),
                                BYTE_W'($urandom)));
            finish_refill(sent);
            items += 1 + sent;
         end
         // occasionally let every pending result come back
         if ($urandom_range(0, 24) == 0) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_small_window_refill();
      test_hit_after_shrink();

      // goals leave room for the refill that ends each run
      test_random_traffic(16'd40, 20, 1'b1);
      test_random_traffic(16'hffff, 20, 1'b1);
      test_random_traffic(16'd33, 20, 1'b0);
      test_random_traffic(16'd32, 20, 1'b1);
      test_random_traffic(16'd31, 15, 1'b1);
      test_random_traffic(16'd1, 15, 1'b1);
      test_random_traffic(16'd300, 20, 1'b1);
      test_random_traffic(16'd0, 10, 1'b1);
      test_random_traffic(16'($urandom), 20, 1'b1);
      test_random_traffic(16'hffff, 10, 1'b1);

      drain_results();
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
